@@ rtl/sled_pkg.sv @@
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types and constants for the serial line editor with LED commands.
// ----------------------------------------------------------------------------
package sled_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam int SHADOW_LEN    = 7;   // longest command word (LED_OFF)

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [7:0] LEVEL_FULL = 8'hFF;

    localparam logic [55:0] WORD_OFF   = "LED_OFF";
    localparam logic [47:0] WORD_ON    = "LED_ON";
    localparam logic [39:0] WORD_GREEN = "GREEN";
    localparam logic [31:0] WORD_BLUE  = "BLUE";
    localparam logic [23:0] WORD_RED   = "RED";

    // colour bits: 0 red, 1 green, 2 blue
    localparam logic [2:0] COL_ON    = 3'b111;
    localparam logic [2:0] COL_OFF   = 3'b000;
    localparam logic [2:0] COL_RED   = 3'b001;
    localparam logic [2:0] COL_GREEN = 3'b010;
    localparam logic [2:0] COL_BLUE  = 3'b100;

    typedef enum logic [1:0] {
        K_PRINT,
        K_ERASE,
        K_EOL
    } t_kind;

    typedef enum logic [1:0] {
        STAT_NONE,
        STAT_OK,
        STAT_UNKNOWN
    } t_status;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        t_status    status;
        logic [2:0] colour;
    } t_op;

endpackage

@@ rtl/sled_front.sv @@
// ----------------------------------------------------------------------------
// sled_front
// Accepts received bytes, edits the line, matches commands on end of line and
// queues one echo operation per byte that produces output.
// ----------------------------------------------------------------------------
module sled_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_cmd,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_q_full,
    output logic             o_push,
    output sled_pkg::t_op    o_op
);

    logic [sled_pkg::LEN_W-1:0] r_len, n_len;
    logic [2:0]                 r_colour, n_colour;
    // Only the head of the line can ever match a command word, so only
    // that many characters are kept.
    logic [7:0]                 r_chars [0:sled_pkg::SHADOW_LEN-1];

    logic accept;
    logic printable;
    logic is_eol;
    logic is_erase;
    logic line_full;
    logic wr_char;
    logic m_on, m_off, m_red, m_green, m_blue;
    logic [2:0] match_colour;
    sled_pkg::t_status match_status;

    assign o_stall   = i_q_full;
    assign accept    = i_valid && !i_q_full;
    assign printable = i_rx_byte inside {[sled_pkg::CH_SPACE:sled_pkg::CH_TILDE]};
    assign is_eol    = (i_rx_byte == sled_pkg::CH_CR) || (i_rx_byte == sled_pkg::CH_LF);
    assign is_erase  = (i_rx_byte == sled_pkg::CH_BS) || (i_rx_byte == sled_pkg::CH_DEL);
    assign line_full = (r_len == sled_pkg::LEN_W'(sled_pkg::LINE_CAPACITY - 1));
    assign wr_char   = accept && !i_cmd && printable && !line_full;

    assign m_on    = (r_len == sled_pkg::LEN_W'(6)) &&
                     ({r_chars[0], r_chars[1], r_chars[2], r_chars[3], r_chars[4],
                       r_chars[5]} == sled_pkg::WORD_ON);
    assign m_off   = (r_len == sled_pkg::LEN_W'(7)) &&
                     ({r_chars[0], r_chars[1], r_chars[2], r_chars[3], r_chars[4],
                       r_chars[5], r_chars[6]} == sled_pkg::WORD_OFF);
    assign m_red   = (r_len == sled_pkg::LEN_W'(3)) &&
                     ({r_chars[0], r_chars[1], r_chars[2]} == sled_pkg::WORD_RED);
    assign m_green = (r_len == sled_pkg::LEN_W'(5)) &&
                     ({r_chars[0], r_chars[1], r_chars[2], r_chars[3],
                       r_chars[4]} == sled_pkg::WORD_GREEN);
    assign m_blue  = (r_len == sled_pkg::LEN_W'(4)) &&
                     ({r_chars[0], r_chars[1], r_chars[2], r_chars[3]} == sled_pkg::WORD_BLUE);

    always_comb begin
        match_colour = r_colour;
        if (m_on) begin
            match_colour = sled_pkg::COL_ON;
        end else if (m_off) begin
            match_colour = sled_pkg::COL_OFF;
        end else if (m_red) begin
            match_colour = sled_pkg::COL_RED;
        end else if (m_green) begin
            match_colour = sled_pkg::COL_GREEN;
        end else if (m_blue) begin
            match_colour = sled_pkg::COL_BLUE;
        end
        if (r_len == '0) begin
            match_status = sled_pkg::STAT_NONE;
        end else if (m_on || m_off || m_red || m_green || m_blue) begin
            match_status = sled_pkg::STAT_OK;
        end else begin
            match_status = sled_pkg::STAT_UNKNOWN;
        end
    end

    always_comb begin
        n_len         = r_len;
        n_colour      = r_colour;
        o_push        = 1'b0;
        o_op.kind     = sled_pkg::K_PRINT;
        o_op.ch       = i_rx_byte;
        o_op.status   = sled_pkg::STAT_NONE;
        if (accept) begin
            if (i_cmd) begin
                n_len = '0;
            end else if (is_eol) begin
                n_len       = '0;
                n_colour    = match_colour;
                o_push      = 1'b1;
                o_op.kind   = sled_pkg::K_EOL;
                o_op.status = match_status;
            end else if (is_erase) begin
                if (r_len != '0) begin
                    n_len     = r_len - 1'b1;
                    o_push    = 1'b1;
                    o_op.kind = sled_pkg::K_ERASE;
                end
            end else if (printable && !line_full) begin
                n_len  = r_len + 1'b1;
                o_push = 1'b1;
            end
        end
        o_op.colour = n_colour;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_colour <= sled_pkg::COL_OFF;
        end else begin
            r_len    <= n_len;
            r_colour <= n_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < sled_pkg::SHADOW_LEN; i++) begin
            if (wr_char && (r_len == sled_pkg::LEN_W'(i))) begin
                r_chars[i] <= i_rx_byte;
            end
        end
    end

endmodule

@@ rtl/sled_queue.sv @@
// ----------------------------------------------------------------------------
// sled_queue
// Short queue of echo operations between the line editor and the echo
// sequencer.
// ----------------------------------------------------------------------------
module sled_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sled_pkg::t_op    i_op,
    output logic             o_full,
    output logic             o_valid,
    output sled_pkg::t_op    o_op,
    input  logic             i_pop
);

    sled_pkg::t_op               r_mem [0:sled_pkg::QDEPTH-1];
    logic [sled_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [sled_pkg::QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == sled_pkg::QCNT_W'(sled_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

endmodule

@@ rtl/sled_back.sv @@
// ----------------------------------------------------------------------------
// sled_back
// Echo sequencer: expands each queued operation into one to three echo
// transfers through a registered output stage.
// ----------------------------------------------------------------------------
module sled_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  sled_pkg::t_op    i_op,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_tx_byte,
    output logic [2:0]       o_colour,
    output logic             o_led_update,
    output logic [1:0]       o_command_status,
    output logic             o_last
);

    logic [1:0]        r_beat;
    logic              r_valid;
    logic [7:0]        r_tx;
    logic [2:0]        r_colour;
    logic              r_upd;
    sled_pkg::t_status r_status;
    logic              r_last;

    logic              load;
    logic              last_beat;
    logic [7:0]        n_tx;
    logic              n_upd;
    sled_pkg::t_status n_status;

    assign load = i_q_valid && (!r_valid || !i_stall);

    always_comb begin
        last_beat = 1'b1;
        n_tx      = i_op.ch;
        n_upd     = 1'b0;
        n_status  = sled_pkg::STAT_NONE;
        case (i_op.kind)
            sled_pkg::K_PRINT: begin
                last_beat = 1'b1;
                n_tx      = i_op.ch;
            end
            sled_pkg::K_ERASE: begin
                last_beat = (r_beat == 2'd2);
                n_tx      = (r_beat == 2'd1) ? sled_pkg::CH_SPACE : sled_pkg::CH_BS;
            end
            sled_pkg::K_EOL: begin
                last_beat = (r_beat == 2'd1);
                n_tx      = (r_beat == 2'd0) ? sled_pkg::CH_CR : sled_pkg::CH_LF;
                if (r_beat == 2'd1) begin
                    n_status = i_op.status;
                    n_upd    = (i_op.status == sled_pkg::STAT_OK);
                end
            end
            default: begin
                last_beat = 1'b1;
            end
        endcase
    end

    assign o_pop = load && last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_beat <= last_beat ? 2'd0 : r_beat + 2'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tx     <= n_tx;
            r_colour <= i_op.colour;
            r_upd    <= n_upd;
            r_status <= n_status;
            r_last   <= last_beat;
        end
    end

    assign o_valid          = r_valid;
    assign o_tx_byte        = r_tx;
    assign o_colour         = r_colour;
    assign o_led_update     = r_upd;
    assign o_command_status = r_status;
    assign o_last           = r_last;

    a_update_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_upd |-> r_last && (r_status == sled_pkg::STAT_OK))
        else $error("led update outside final ok transfer");

    a_status_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last |-> (r_status == sled_pkg::STAT_NONE))
        else $error("command status on non-final transfer");

    a_beat_holds_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beat != 2'd0) |-> i_q_valid && (i_op.kind != sled_pkg::K_PRINT))
        else $error("sequencer mid-operation without a queued operation");

endmodule

@@ rtl/serial_line_editor_led_command.sv @@
// ----------------------------------------------------------------------------
// serial_line_editor_led_command
// Serial line editor: echoes edits and sets the LED colour on command lines.
// ----------------------------------------------------------------------------
// The first echo transfer of an accepted byte passes through a queue entry
// and then the output register. One echo transfer per cycle while echoes are
// queued and i_stall is low; a byte gives 0 to 3 (printable 1, end of line 2, erase 3).
// A four-entry queue lets bytes be accepted while earlier echoes drain.
// Reset (synchronous, active low) empties the line and queue, sets the line
// colour to off and drops any pending echo; the LED outputs are not reset.
module serial_line_editor_led_command (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_tx_byte,
    output logic [7:0] o_led_red,
    output logic [7:0] o_led_green,
    output logic [7:0] o_led_blue,
    output logic       o_led_update,
    output logic [1:0] o_command_status,
    output logic       o_last
);

    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    sled_pkg::t_op push_op;
    sled_pkg::t_op head_op;
    logic [2:0]    colour;

    sled_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_cmd     (i_cmd),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_op      (push_op)
    );

    sled_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (head_op),
        .i_pop   (q_pop)
    );

    sled_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_op             (head_op),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_tx_byte        (o_tx_byte),
        .o_colour         (colour),
        .o_led_update     (o_led_update),
        .o_command_status (o_command_status),
        .o_last           (o_last)
    );

    assign o_led_red   = colour[0] ? sled_pkg::LEVEL_FULL : 8'h00;
    assign o_led_green = colour[1] ? sled_pkg::LEVEL_FULL : 8'h00;
    assign o_led_blue  = colour[2] ? sled_pkg::LEVEL_FULL : 8'h00;

endmodule

@@ bench/tb_serial_line_editor_led_command.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_line_editor_led_command
// Drives received bytes and flushes into the line editor and checks every
// echo transfer against a cycle-free model of the line buffer and LED colour.
// Command words, random lines with erasing, overflowing lines and noise bytes
// are sent with random idle bursts on both handshakes.
// ----------------------------------------------------------------------------
module tb_serial_line_editor_led_command;

    localparam int ITEMS_TOTAL = 370;
    localparam int QUIET_TAIL  = 60;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [7:0]        tx;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic              upd;
        sled_pkg::t_status status;
        logic              last;
    } t_echo_beat;

    class echo_scoreboard;
        logic [7:0]  line_buf [sled_pkg::LINE_CAPACITY];
        int          line_len = 0;
        logic [2:0]  colour = sled_pkg::COL_OFF;
        t_echo_beat  pending_q [$];
        int          failures = 0;

        function sled_pkg::t_status match_line();
            logic [55:0] text;
            int          i;
            text = '0;
            if (line_len == 0) return sled_pkg::STAT_NONE;
            for (i = 0; i < line_len && i < sled_pkg::SHADOW_LEN; i++)
                text = {text[47:0], line_buf[i]};
            if (line_len == 6 && text[47:0] == sled_pkg::WORD_ON)
                colour = sled_pkg::COL_ON;
            else if (line_len == 7 && text == sled_pkg::WORD_OFF)
                colour = sled_pkg::COL_OFF;
            else if (line_len == 3 && text[23:0] == sled_pkg::WORD_RED)
                colour = sled_pkg::COL_RED;
            else if (line_len == 5 && text[39:0] == sled_pkg::WORD_GREEN)
                colour = sled_pkg::COL_GREEN;
            else if (line_len == 4 && text[31:0] == sled_pkg::WORD_BLUE)
                colour = sled_pkg::COL_BLUE;
            else return sled_pkg::STAT_UNKNOWN;
            return sled_pkg::STAT_OK;
        endfunction

        function void push_beat(logic [7:0] tx, logic upd, sled_pkg::t_status st,
                                logic last);
            t_echo_beat b;
            b.tx     = tx;
            b.red    = colour[0] ? sled_pkg::LEVEL_FULL : 8'h00;
            b.green  = colour[1] ? sled_pkg::LEVEL_FULL : 8'h00;
            b.blue   = colour[2] ? sled_pkg::LEVEL_FULL : 8'h00;
            b.upd    = upd;
            b.status = st;
            b.last   = last;
            pending_q.push_back(b);
        endfunction

        // Returns the number of echo transfers the byte causes.
        function int note_input(bit flush, logic [7:0] ch);
            sled_pkg::t_status st;
            if (flush) begin
                line_len = 0;
                return 0;
            end
            if (ch == sled_pkg::CH_CR || ch == sled_pkg::CH_LF) begin
                st = match_line();
                line_len = 0;
                push_beat(sled_pkg::CH_CR, 1'b0, sled_pkg::STAT_NONE, 1'b0);
                push_beat(sled_pkg::CH_LF, st == sled_pkg::STAT_OK, st, 1'b1);
                return 2;
            end
            if (ch == sled_pkg::CH_BS || ch == sled_pkg::CH_DEL) begin
                if (line_len == 0) return 0;
                line_len--;
                push_beat(sled_pkg::CH_BS, 1'b0, sled_pkg::STAT_NONE, 1'b0);
                push_beat(sled_pkg::CH_SPACE, 1'b0, sled_pkg::STAT_NONE, 1'b0);
                push_beat(sled_pkg::CH_BS, 1'b0, sled_pkg::STAT_NONE, 1'b1);
                return 3;
            end
            if (ch >= sled_pkg::CH_SPACE && ch <= sled_pkg::CH_TILDE) begin
                // keep one slot free, as the line holds capacity minus one
                if (line_len + 1 >= sled_pkg::LINE_CAPACITY) return 0;
                line_buf[line_len] = ch;
                line_len++;
                push_beat(ch, 1'b0, sled_pkg::STAT_NONE, 1'b1);
                return 1;
            end
            return 0;
        endfunction

        function void check_result(logic [7:0] tx, logic [7:0] red, logic [7:0] green,
                                   logic [7:0] blue, logic upd, logic [1:0] st,
                                   logic last);
            t_echo_beat e;
            if (pending_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected echo transfer: tx=%h last=%b", tx, last);
                return;
            end
            e = pending_q.pop_front();
            if (tx !== e.tx || red !== e.red || green !== e.green || blue !== e.blue ||
                upd !== e.upd || st !== e.status || last !== e.last) begin
                failures++;
                if (failures <= 10) begin
                    $display("echo mismatch: expected tx=%h rgb=%h/%h/%h upd=%b st=%0d last=%b",
                             e.tx, e.red, e.green, e.blue, e.upd, e.status, e.last);
                    $display("               got      tx=%h rgb=%h/%h/%h upd=%b st=%0d last=%b",
                             tx, red, green, blue, upd, st, last);
                end
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_cmd = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_tx_byte;
    logic [7:0] o_led_red;
    logic [7:0] o_led_green;
    logic [7:0] o_led_blue;
    logic       o_led_update;
    logic [1:0] o_command_status;
    logic       o_last;

    echo_scoreboard board = new();
    bit             idle_en = 1'b1;
    int             stall_left = 0;
    int             active_items = 0;
    int             cycle_count = 0;

    serial_line_editor_led_command dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_tx_byte        (o_tx_byte),
        .o_led_red        (o_led_red),
        .o_led_green      (o_led_green),
        .o_led_blue       (o_led_blue),
        .o_led_update     (o_led_update),
        .o_command_status (o_command_status),
        .o_last           (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Check the echo transfer, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_tx_byte, o_led_red, o_led_green, o_led_blue,
                               o_led_update, o_command_status, o_last);
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic push_byte(input bit flush, input logic [7:0] ch);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_cmd     <= flush;
        i_rx_byte <= ch;
        do @(posedge i_clk); while (o_stall);
        void'(board.note_input(flush, ch));
        active_items++;
    endtask

    task automatic type_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) push_byte(1'b0, s[i]);
    endtask

    task automatic end_line();
        push_byte(1'b0, $urandom_range(0, 1) ? sled_pkg::CH_CR : sled_pkg::CH_LF);
    endtask

    function automatic logic [7:0] any_printable();
        return 8'($urandom_range(sled_pkg::CH_SPACE, sled_pkg::CH_TILDE));
    endfunction

    function automatic logic [7:0] any_erase();
        return $urandom_range(0, 1) ? sled_pkg::CH_BS : sled_pkg::CH_DEL;
    endfunction

    task automatic send_command_line();
        string words [5] = '{"LED_ON", "LED_OFF", "RED", "GREEN", "BLUE"};
        string w;
        w = words[$urandom_range(0, 4)];
        // a typo fixed by erasing still yields a clean command
        if ($urandom_range(0, 3) == 0) begin
            push_byte(1'b0, any_printable());
            push_byte(1'b0, any_erase());
        end
        if ($urandom_range(0, 7) == 0)
            type_text(w.substr(0, w.len() - 2));
        else
            type_text(w);
        if ($urandom_range(0, 7) == 0) push_byte(1'b0, any_printable());
        if ($urandom_range(0, 9) == 0) push_byte(1'b1, 8'($urandom_range(0, 255)));
        end_line();
    endtask

    task automatic send_random_line();
        int n;
        int i;
        n = $urandom_range(0, 12);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) push_byte(1'b0, any_erase());
            else push_byte(1'b0, any_printable());
        end
        end_line();
    endtask

    // Fill the buffer to near or past its limit, erase a little, refill and terminate.
    task automatic send_long_line();
        int n;
        int i;
        n = $urandom_range(sled_pkg::LINE_CAPACITY - 4, sled_pkg::LINE_CAPACITY + 6);
        for (i = 0; i < n; i++) push_byte(1'b0, any_printable());
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) push_byte(1'b0, any_erase());
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) push_byte(1'b0, any_printable());
        end_line();
    endtask

    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
            push_byte($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int pick;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty lines, erase on empty, drops, extremes, flush
        push_byte(1'b0, sled_pkg::CH_CR);
        push_byte(1'b0, sled_pkg::CH_BS);
        push_byte(1'b0, sled_pkg::CH_DEL);
        type_text("RED");
        push_byte(1'b0, sled_pkg::CH_LF);
        push_byte(1'b0, 8'h00);
        push_byte(1'b0, 8'hFF);
        push_byte(1'b0, 8'h80);
        push_byte(1'b0, 8'h1B);
        push_byte(1'b0, sled_pkg::CH_SPACE);
        push_byte(1'b0, sled_pkg::CH_TILDE);
        push_byte(1'b0, sled_pkg::CH_DEL);
        push_byte(1'b0, sled_pkg::CH_BS);
        type_text("X");
        push_byte(1'b1, 8'hA5);
        push_byte(1'b0, sled_pkg::CH_LF);
        type_text("Q");
        push_byte(1'b0, sled_pkg::CH_CR);
        type_text("BLUE");
        push_byte(1'b1, 8'h5A);
        push_byte(1'b0, sled_pkg::CH_CR);

        send_long_line();
        while (active_items < ITEMS_TOTAL) begin
            if (active_items >= ITEMS_TOTAL - QUIET_TAIL) idle_en = 1'b0;
            else idle_en = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 50)      send_command_line();
            else if (pick < 74) send_random_line();
            else if (pick < 76) send_long_line();
            else                send_noise();
        end
        idle_en = 1'b0;
        i_valid <= 1'b0;

        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sled_pkg.sv
rtl/sled_front.sv
rtl/sled_queue.sv
rtl/sled_back.sv
rtl/serial_line_editor_led_command.sv
bench/tb_serial_line_editor_led_command.sv
